FILE: hw/rtl/particle_attractor_accel_core_macros.svh
// Assertion macros used by the RTL of the particle attractor core (pa_fifo).
// The expanding module must have clk and arst_n in scope.
`ifndef PARTICLE_ATTRACTOR_ACCEL_CORE_MACROS_SVH
`define PARTICLE_ATTRACTOR_ACCEL_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PA_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");
`define PA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define PA_ASSERT_NEVER(lbl, expr)
`define PA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/pa_pkg.sv
// ----------------------------------------------------------------------------
// pa_pkg
// Types and constants of the particle attractor core.
// ----------------------------------------------------------------------------
package pa_pkg;

	localparam int PA_MAX_ATTR    = 4;
	localparam int PA_QUEUE_DEPTH = 4;

	localparam int POS_W   = 20;
	localparam int OFF_W   = POS_W + 1;
	localparam int STR_W   = 24;
	localparam int ACC_W   = 32;
	localparam int PROD_W  = OFF_W + STR_W;      // offset * strength
	localparam int SQ_W    = 2 * POS_W + 1;      // offset squared
	localparam int DEN_W   = SQ_W + 1;           // squared distance
	localparam int NUM_W   = PROD_W - 1 + 8;     // |offset * strength| * 256
	localparam int QUO_W   = 32;                 // |quotient| <= 2^31
	localparam int TERM_W  = QUO_W + 1;
	localparam int SUM_W   = ACC_W + 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WORD0 = 3'd1;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [STR_W-1:0] strength;
	} pa_attr_t;

	typedef struct packed {
		logic signed [OFF_W-1:0] ox;
		logic signed [OFF_W-1:0] oy;
		logic                    active;
	} pa_lane_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] acc_x;
		logic signed [ACC_W-1:0] acc_y;
		logic                    last;
		logic                    coinc;
	} pa_side_t;

endpackage

FILE: hw/rtl/pa_in_if.sv
// ----------------------------------------------------------------------------
// pa_in_if
// Particle input channel: valid/ready with position and acceleration.
// ----------------------------------------------------------------------------
interface pa_in_if;
	import pa_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [ACC_W-1:0] acc_in_x;
	logic signed [ACC_W-1:0] acc_in_y;
	logic                    last_particle;

	modport source (output valid, pos_x, pos_y, acc_in_x, acc_in_y, last_particle,
		input ready);
	modport sink (input valid, pos_x, pos_y, acc_in_x, acc_in_y, last_particle,
		output ready);
endinterface

FILE: hw/rtl/pa_out_if.sv
// ----------------------------------------------------------------------------
// pa_out_if
// Acceleration result channel: valid/ready with result and flags.
// ----------------------------------------------------------------------------
interface pa_out_if;
	import pa_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [ACC_W-1:0] acc_out_x;
	logic signed [ACC_W-1:0] acc_out_y;
	logic                    saturated;
	logic                    coincident;
	logic                    last_out;

	modport source (output valid, acc_out_x, acc_out_y, saturated, coincident,
		last_out, input ready);
	modport sink (input valid, acc_out_x, acc_out_y, saturated, coincident,
		last_out, output ready);
endinterface

FILE: hw/rtl/particle_attractor_accel_core.sv
// ----------------------------------------------------------------------------
// particle_attractor_accel_core
// Inverse-square point attractor force on a stream of particles.
// ----------------------------------------------------------------------------
//  channel   | dir  | transaction payload
//  particle  | in   | pos_x, pos_y, acc_in_x, acc_in_y, last_particle
//  accel     | out  | acc_out_x, acc_out_y, saturated, coincident, last_out
//  cfg       | in   | cfg_we, cfg_index, cfg_wdata (write only)
//
// One particle per cycle sustained while accel.ready stays high; the
// 32-stage restoring dividers sit two per attractor lane.
// A 4-entry queue sits between the front and the back part.
// The back pipeline freezes as a whole while a result waits on accel.ready;
// the front keeps taking transactions until the queue fills.
// Reset clears the registers (count 0, words 0) and all valid flags; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module particle_attractor_accel_core #(
	parameter int MAX_ATTRACTORS = pa_pkg::PA_MAX_ATTR
) (
	input  logic                           clk,
	input  logic                           arst_n,
	pa_in_if.sink                          particle,
	pa_out_if.source                       accel,
	input  logic                           cfg_we,
	input  logic [pa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pa_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import pa_pkg::*;

	localparam int CNT_W  = 3;
	localparam int ITEM_W = MAX_ATTRACTORS * $bits(pa_lane_t) + $bits(pa_side_t);

	// configuration registers
	logic [CNT_W-1:0]                  count_q;
	pa_attr_t [MAX_ATTRACTORS-1:0]     attr_q;
	logic [MAX_ATTRACTORS-1:0]         lane_en;

	// front -> queue -> back
	logic                              push, full, pop, empty;
	pa_lane_t [MAX_ATTRACTORS-1:0]     f_lanes, b_lanes;
	pa_side_t                          f_side, b_side;
	logic [ITEM_W-1:0]                 q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we && (cfg_index == REG_COUNT)) begin
			count_q <= cfg_wdata[CNT_W-1:0];
		end
	end

	// words past the attractor lanes are accepted and dropped
	for (genvar a = 0; a < MAX_ATTRACTORS; a++) begin : g_word
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				attr_q[a] <= '0;
			end else if (cfg_we && (cfg_index == REG_WORD0 + CFG_IDX_W'(a))) begin
				attr_q[a] <= cfg_wdata;
			end
		end
		// count above the lane number enables that lane
		assign lane_en[a] = (count_q > CNT_W'(a));
	end

	pa_front #(.MAX_ATTRACTORS(MAX_ATTRACTORS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.particle (particle),
		.attr     (attr_q),
		.lane_en  (lane_en),
		.push     (push),
		.full     (full),
		.lanes    (f_lanes),
		.side     (f_side)
	);

	pa_fifo #(.WIDTH(ITEM_W), .DEPTH(PA_QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({f_lanes, f_side}),
		.full   (full),
		.pop    (pop),
		.rdata  (q_rdata),
		.empty  (empty)
	);

	assign {b_lanes, b_side} = q_rdata;

	pa_back #(.MAX_ATTRACTORS(MAX_ATTRACTORS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (!empty),
		.pop     (pop),
		.lanes   (b_lanes),
		.side    (b_side),
		.attr    (attr_q),
		.accel   (accel)
	);

endmodule

FILE: hw/rtl/pa_fifo.sv
// ----------------------------------------------------------------------------
// pa_fifo
// Small flop queue between the front and back parts.
// ----------------------------------------------------------------------------
`include "particle_attractor_accel_core_macros.svh"

module pa_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PA_ASSERT_NEVER(a_no_overflow, push && full)
	`PA_ASSERT_NEVER(a_no_underflow, pop && empty)
	`PA_ASSERT_NEXT(a_push_fills, push, !empty)

endmodule

FILE: hw/rtl/pa_div.sv
// ----------------------------------------------------------------------------
// pa_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pa_div #(
	parameter int NUM_W = 52,
	parameter int DEN_W = 42,
	parameter int QUO_W = 32
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic             neg,
	output logic [QUO_W-1:0] quo,
	output logic             quo_neg
);
	// quotient must fit QUO_W bits: num < den * 2^QUO_W
	logic [DEN_W-1:0] rem_s [QUO_W];
	logic [QUO_W-1:0] lo_s  [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W+1];
	logic             neg_s [QUO_W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DEN_W'(num[NUM_W-1:QUO_W]);
			lo_s[0]  <= num[QUO_W-1:0];
			den_s[0] <= den;
			quo_s[0] <= '0;
			neg_s[0] <= neg;
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [DEN_W:0] trial;
		logic           ge;
		logic [DEN_W:0] diff;

		assign trial = {rem_s[k], lo_s[k][QUO_W-1]};
		assign ge    = (trial >= {1'b0, den_s[k]});
		assign diff  = trial - {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k+1] <= {quo_s[k][QUO_W-2:0], ge};
				neg_s[k+1] <= neg_s[k];
			end
		end

		if (k + 1 < QUO_W) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
					lo_s[k+1]  <= {lo_s[k][QUO_W-2:0], 1'b0};
					den_s[k+1] <= den_s[k];
				end
			end
		end
	end

	assign quo     = quo_s[QUO_W];
	assign quo_neg = neg_s[QUO_W];

endmodule

FILE: hw/rtl/pa_front.sv
// ----------------------------------------------------------------------------
// pa_front
// Accepts particles, forms attractor offsets, flags coincident terms.
// ----------------------------------------------------------------------------
module pa_front #(
	parameter int MAX_ATTRACTORS = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	pa_in_if.sink                                particle,
	input  pa_pkg::pa_attr_t [MAX_ATTRACTORS-1:0] attr,
	input  logic [MAX_ATTRACTORS-1:0]            lane_en,
	output logic                                 push,
	input  logic                                 full,
	output pa_pkg::pa_lane_t [MAX_ATTRACTORS-1:0] lanes,
	output pa_pkg::pa_side_t                     side
);
	import pa_pkg::*;

	logic                              vld_s1;
	pa_lane_t [MAX_ATTRACTORS-1:0]     lanes_s1;
	pa_side_t                          side_s1;
	pa_lane_t [MAX_ATTRACTORS-1:0]     lanes_d;
	logic                              coinc_d;
	logic                              take;

	assign particle.ready = !vld_s1 || !full;
	assign take = particle.valid && particle.ready;

	always_comb begin
		coinc_d = 1'b0;
		for (int a = 0; a < MAX_ATTRACTORS; a++) begin
			lanes_d[a].ox = OFF_W'(attr[a].x) - OFF_W'(particle.pos_x);
			lanes_d[a].oy = OFF_W'(attr[a].y) - OFF_W'(particle.pos_y);
			lanes_d[a].active = lane_en[a] &&
				((lanes_d[a].ox != '0) || (lanes_d[a].oy != '0));
			if (lane_en[a] && (lanes_d[a].ox == '0) && (lanes_d[a].oy == '0)) begin
				coinc_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (particle.ready) begin
			vld_s1 <= particle.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			lanes_s1      <= lanes_d;
			side_s1.acc_x <= particle.acc_in_x;
			side_s1.acc_y <= particle.acc_in_y;
			side_s1.last  <= particle.last_particle;
			side_s1.coinc <= coinc_d;
		end
	end

	assign push  = vld_s1 && !full;
	assign lanes = lanes_s1;
	assign side  = side_s1;

endmodule

FILE: hw/rtl/pa_back.sv
// ----------------------------------------------------------------------------
// pa_back
// Products, per-lane dividers, summation and saturation of one particle.
// ----------------------------------------------------------------------------
module pa_back #(
	parameter int MAX_ATTRACTORS = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_valid,
	output logic                                 pop,
	input  pa_pkg::pa_lane_t [MAX_ATTRACTORS-1:0] lanes,
	input  pa_pkg::pa_side_t                     side,
	input  pa_pkg::pa_attr_t [MAX_ATTRACTORS-1:0] attr,
	pa_out_if.source                             accel
);
	import pa_pkg::*;

	localparam int DIV_LAT = QUO_W + 1;

	logic en;

	// stage 1: products
	logic                          vld_s1;
	pa_side_t                      side_s1;
	logic [MAX_ATTRACTORS-1:0]     act_s1;
	logic signed [PROD_W-1:0]      prodx_s1 [MAX_ATTRACTORS];
	logic signed [PROD_W-1:0]      prody_s1 [MAX_ATTRACTORS];
	logic [SQ_W-1:0]               sqx_s1   [MAX_ATTRACTORS];
	logic [SQ_W-1:0]               sqy_s1   [MAX_ATTRACTORS];

	// sideband alongside the dividers
	logic                          vld_p  [DIV_LAT];
	pa_side_t                      side_p [DIV_LAT];
	logic [MAX_ATTRACTORS-1:0]     act_p  [DIV_LAT];

	logic [QUO_W-1:0]              qx [MAX_ATTRACTORS];
	logic [QUO_W-1:0]              qy [MAX_ATTRACTORS];
	logic                          nx [MAX_ATTRACTORS];
	logic                          ny [MAX_ATTRACTORS];

	// sum stage
	logic                          vld_s3;
	logic signed [SUM_W-1:0]       sumx_s3, sumy_s3;
	logic                          last_s3, coinc_s3;
	logic signed [SUM_W-1:0]       sumx_d, sumy_d;

	// output register
	logic                          out_vld_q;
	logic signed [ACC_W-1:0]       accx_q, accy_q;
	logic                          sat_q, coinc_q, last_q;
	logic signed [ACC_W-1:0]       satx_d, saty_d;
	logic                          ovx_d, ovy_d;

	assign en  = !out_vld_q || accel.ready;
	assign pop = en && q_valid;

	for (genvar l = 0; l < MAX_ATTRACTORS; l++) begin : g_lane
		logic signed [2*OFF_W-1:0] sqx_w, sqy_w;
		logic [PROD_W-1:0]         magx, magy;
		logic [DEN_W-1:0]          d2;

		assign sqx_w = lanes[l].ox * lanes[l].ox;
		assign sqy_w = lanes[l].oy * lanes[l].oy;

		always_ff @(posedge clk) begin
			if (en) begin
				prodx_s1[l] <= lanes[l].ox * attr[l].strength;
				prody_s1[l] <= lanes[l].oy * attr[l].strength;
				sqx_s1[l]   <= sqx_w[SQ_W-1:0];
				sqy_s1[l]   <= sqy_w[SQ_W-1:0];
			end
		end

		assign d2   = {1'b0, sqx_s1[l]} + {1'b0, sqy_s1[l]};
		assign magx = prodx_s1[l][PROD_W-1] ? -prodx_s1[l] : prodx_s1[l];
		assign magy = prody_s1[l][PROD_W-1] ? -prody_s1[l] : prody_s1[l];

		pa_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_x (
			.clk     (clk),
			.en      (en),
			.num     ({magx[PROD_W-2:0], 8'b0}),
			.den     (d2),
			.neg     (prodx_s1[l][PROD_W-1]),
			.quo     (qx[l]),
			.quo_neg (nx[l])
		);

		pa_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_y (
			.clk     (clk),
			.en      (en),
			.num     ({magy[PROD_W-2:0], 8'b0}),
			.den     (d2),
			.neg     (prody_s1[l][PROD_W-1]),
			.quo     (qy[l]),
			.quo_neg (ny[l])
		);
	end

	always_comb begin
		logic signed [TERM_W-1:0] tx, ty;
		sumx_d = SUM_W'(side_p[DIV_LAT-1].acc_x);
		sumy_d = SUM_W'(side_p[DIV_LAT-1].acc_y);
		for (int l = 0; l < MAX_ATTRACTORS; l++) begin
			tx = nx[l] ? -$signed({1'b0, qx[l]}) : $signed({1'b0, qx[l]});
			ty = ny[l] ? -$signed({1'b0, qy[l]}) : $signed({1'b0, qy[l]});
			if (act_p[DIV_LAT-1][l]) begin
				sumx_d = sumx_d + SUM_W'(tx);
				sumy_d = sumy_d + SUM_W'(ty);
			end
		end
	end

	// clip when the bits above the result sign disagree with it
	assign ovx_d  = (sumx_s3[SUM_W-1:ACC_W-1] != '0) && (sumx_s3[SUM_W-1:ACC_W-1] != '1);
	assign ovy_d  = (sumy_s3[SUM_W-1:ACC_W-1] != '0) && (sumy_s3[SUM_W-1:ACC_W-1] != '1);
	assign satx_d = ovx_d ? {sumx_s3[SUM_W-1], {(ACC_W-1){~sumx_s3[SUM_W-1]}}}
		: sumx_s3[ACC_W-1:0];
	assign saty_d = ovy_d ? {sumy_s3[SUM_W-1], {(ACC_W-1){~sumy_s3[SUM_W-1]}}}
		: sumy_s3[ACC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) begin
				vld_p[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s1 <= q_valid;
			vld_p[0] <= vld_s1;
			for (int i = 1; i < DIV_LAT; i++) begin
				vld_p[i] <= vld_p[i-1];
			end
			vld_s3    <= vld_p[DIV_LAT-1];
			out_vld_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side;
			for (int l = 0; l < MAX_ATTRACTORS; l++) begin
				act_s1[l] <= lanes[l].active;
			end
			side_p[0] <= side_s1;
			act_p[0]  <= act_s1;
			for (int i = 1; i < DIV_LAT; i++) begin
				side_p[i] <= side_p[i-1];
				act_p[i]  <= act_p[i-1];
			end
			sumx_s3  <= sumx_d;
			sumy_s3  <= sumy_d;
			last_s3  <= side_p[DIV_LAT-1].last;
			coinc_s3 <= side_p[DIV_LAT-1].coinc;
			accx_q   <= satx_d;
			accy_q   <= saty_d;
			sat_q    <= ovx_d || ovy_d;
			coinc_q  <= coinc_s3;
			last_q   <= last_s3;
		end
	end

	assign accel.valid      = out_vld_q;
	assign accel.acc_out_x  = accx_q;
	assign accel.acc_out_y  = accy_q;
	assign accel.saturated  = sat_q;
	assign accel.coincident = coinc_q;
	assign accel.last_out   = last_q;

endmodule
